FILE: src/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Types, opcode, width and trap-code constants for the checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam logic [4:0] C_ADD    = 5'd0;
    localparam logic [4:0] C_SUB    = 5'd1;
    localparam logic [4:0] C_MUL    = 5'd2;
    localparam logic [4:0] C_ADDOVF = 5'd3;
    localparam logic [4:0] C_SUBOVF = 5'd4;
    localparam logic [4:0] C_MULOVF = 5'd5;
    localparam logic [4:0] C_SDIV   = 5'd6;
    localparam logic [4:0] C_UDIV   = 5'd7;
    localparam logic [4:0] C_SREM   = 5'd8;
    localparam logic [4:0] C_UREM   = 5'd9;
    localparam logic [4:0] C_IDXCHK = 5'd10;
    localparam logic [4:0] C_SICAST = 5'd11;
    localparam logic [4:0] C_UICAST = 5'd12;
    localparam logic [4:0] C_XOR    = 5'd13;
    localparam logic [4:0] C_SHL    = 5'd14;
    localparam logic [4:0] C_EQ     = 5'd15;
    localparam logic [4:0] C_NE     = 5'd16;
    localparam logic [4:0] C_GT     = 5'd17;
    localparam logic [4:0] C_LT     = 5'd18;
    localparam logic [4:0] C_LE     = 5'd19;
    localparam logic [4:0] C_GE     = 5'd20;
    localparam logic [4:0] C_LSB    = 5'd21;

    localparam logic [1:0] W_I1  = 2'd0;
    localparam logic [1:0] W_I16 = 2'd1;
    localparam logic [1:0] W_I32 = 2'd2;
    localparam logic [1:0] W_I64 = 2'd3;

    localparam logic [2:0] T_NONE = 3'd0;
    localparam logic [2:0] T_OVF  = 3'd1;
    localparam logic [2:0] T_DIV0 = 3'd2;
    localparam logic [2:0] T_CAST = 3'd3;
    localparam logic [2:0] T_BND  = 3'd4;

    typedef struct packed {
        logic [4:0]         command;
        logic [1:0]         width_sel;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
        logic signed [63:0] operand_c;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result;
        logic [2:0]         trap_code;
    } t_out;

endpackage

FILE: src/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu
// Integer execution unit with overflow, divide, cast and bounds traps.
// ----------------------------------------------------------------------------
// channel | valid     | ready     | payload
// in      | i_valid   | o_ready   | i_data (cia_pkg::t_in)
// out     | o_valid   | i_ready   | o_data (cia_pkg::t_out)
// One transaction per cycle when not stalled; results pass the divider,
// product and output registers. Multiplies use four 32x32 partial products.
// The whole pipe advances when the output register is empty or taken;
// a stall freezes every stage. Reset clears the valid bits only.
module checked_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cia_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cia_pkg::t_out   o_data
);
    localparam int W = DATA_WIDTH;
    localparam int H = W / 2;
    localparam int NS = W + 3;

    typedef struct packed {
        logic [4:0]   cmd;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [63:0]  r;
        logic [2:0]   trap;
        logic         neg;
        logic [6:0]   w;
        logic [2*W-1:0] p;
    } t_ctl;

    localparam int TW = $bits(t_ctl);

    logic adv;
    assign adv = !o_valid || i_ready;
    assign o_ready = adv;

    function automatic logic [W-1:0] f_sx(input logic [W-1:0] v, input logic [6:0] w);
        logic [W-1:0] m;
        m = '1;
        if (w < 7'(W)) begin
            m = ~({W{1'b1}} << w);
            v = v[w-1] ? (v | ~m) : (v & m);
        end
        return v;
    endfunction

    function automatic logic [63:0] f_x64(input logic [W-1:0] v);
        return 64'(signed'(v));
    endfunction

    // ---------------- stage 1: decode, simple ops, divider operands
    logic [W-1:0] a0, b0, c0, x0, y0, mx0, my0, num0, den0;
    logic [6:0]   w0;
    logic [4:0]   cm;
    t_ctl         n_c1;
    logic [W-1:0] s0;
    logic         ovf0;

    always_comb begin
        cm  = i_data.command;
        a0  = i_data.operand_a[W-1:0];
        b0  = i_data.operand_b[W-1:0];
        c0  = i_data.operand_c[W-1:0];
        w0  = (i_data.width_sel == cia_pkg::W_I16) ? 7'd16 :
              (i_data.width_sel == cia_pkg::W_I32) ? 7'd32 : 7'(W);
        x0  = f_sx(a0, w0);
        y0  = f_sx(b0, w0);
        mx0 = x0[W-1] ? -x0 : x0;
        my0 = y0[W-1] ? -y0 : y0;
        n_c1 = '0;
        n_c1.cmd = cm;
        n_c1.a = x0;
        n_c1.b = y0;
        n_c1.w = w0;
        n_c1.neg = x0[W-1] ^ y0[W-1];
        num0 = mx0;
        den0 = my0;
        s0 = '0;
        ovf0 = 1'b0;
        case (cm)
            cia_pkg::C_ADD: n_c1.r = f_x64(a0 + b0);
            cia_pkg::C_SUB: n_c1.r = f_x64(a0 - b0);
            cia_pkg::C_MUL, cia_pkg::C_MULOVF: begin
                if (cm == cia_pkg::C_MUL) begin
                    n_c1.a = a0;
                    n_c1.b = b0;
                end else begin
                    n_c1.a = mx0;
                    n_c1.b = my0;
                end
            end
            cia_pkg::C_ADDOVF, cia_pkg::C_SUBOVF: begin
                if (cm == cia_pkg::C_ADDOVF) begin
                    s0 = x0 + y0;
                    ovf0 = (x0[W-1] == y0[W-1]) && (s0[W-1] != x0[W-1]);
                end else begin
                    s0 = x0 - y0;
                    ovf0 = (x0[W-1] != y0[W-1]) && (s0[W-1] != x0[W-1]);
                end
                if (ovf0 || f_sx(s0, w0) != s0) n_c1.trap = cia_pkg::T_OVF;
                else n_c1.r = f_x64(s0);
            end
            cia_pkg::C_SDIV, cia_pkg::C_SREM: begin
                if (y0 == '0) n_c1.trap = cia_pkg::T_DIV0;
                else if (x0 == f_sx(W'(1) << (w0 - 7'd1), w0) && y0 == '1) begin
                    if (cm == cia_pkg::C_SDIV) n_c1.trap = cia_pkg::T_OVF;
                end
                n_c1.neg = (cm == cia_pkg::C_SDIV) ? (x0[W-1] ^ y0[W-1]) : x0[W-1];
            end
            cia_pkg::C_UDIV, cia_pkg::C_UREM: begin
                num0 = a0;
                den0 = b0;
                n_c1.neg = 1'b0;
                if (b0 == '0) n_c1.trap = cia_pkg::T_DIV0;
            end
            cia_pkg::C_IDXCHK: begin
                if ($signed(x0) < $signed(y0) || $signed(f_sx(c0, w0)) < $signed(x0))
                    n_c1.trap = cia_pkg::T_BND;
                else n_c1.r = f_x64(x0);
            end
            cia_pkg::C_SICAST: begin
                case (i_data.width_sel)
                    cia_pkg::W_I1:  ovf0 = !(a0 == '0 || a0 == W'(1));
                    cia_pkg::W_I16: ovf0 = f_sx(a0, 7'd16) != a0;
                    cia_pkg::W_I32: ovf0 = f_sx(a0, 7'd32) != a0;
                    default:        ovf0 = 1'b0;
                endcase
                if (ovf0) n_c1.trap = cia_pkg::T_CAST;
                else n_c1.r = f_x64(a0);
            end
            cia_pkg::C_UICAST: begin
                case (i_data.width_sel)
                    cia_pkg::W_I1:  ovf0 = a0 > W'(1);
                    cia_pkg::W_I16: ovf0 = a0 > W'(32767);
                    cia_pkg::W_I32: ovf0 = a0 > W'(64'h7FFF_FFFF);
                    default:        ovf0 = 1'b0;
                endcase
                if (ovf0) n_c1.trap = cia_pkg::T_CAST;
                else if (i_data.width_sel == cia_pkg::W_I64) n_c1.r = f_x64(a0);
                else n_c1.r = 64'(a0);
            end
            cia_pkg::C_XOR: n_c1.r = f_x64(a0 ^ b0);
            cia_pkg::C_SHL: n_c1.r = f_x64(a0 << b0[5:0]);
            cia_pkg::C_EQ:  n_c1.r = 64'(a0 == b0);
            cia_pkg::C_NE:  n_c1.r = 64'(a0 != b0);
            cia_pkg::C_GT:  n_c1.r = 64'($signed(b0) < $signed(a0));
            cia_pkg::C_LT:  n_c1.r = 64'($signed(a0) < $signed(b0));
            cia_pkg::C_LE:  n_c1.r = 64'(!($signed(b0) < $signed(a0)));
            cia_pkg::C_GE:  n_c1.r = 64'(!($signed(a0) < $signed(b0)));
            cia_pkg::C_LSB: n_c1.r = 64'(a0[0]);
            default: ;
        endcase
        if (den0 == '0) den0 = W'(1);
    end

    // divider runs alongside; control tag travels with it
    logic [W-1:0] quo, rem;
    t_ctl         dt;
    logic [NS-1:0] r_v;

    cia_div #(.N(W), .TW(TW)) u_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (num0),
        .i_den (den0),
        .i_tag (n_c1),
        .o_quo (quo),
        .o_rem (rem),
        .o_tag (dt)
    );

    // ---------------- stage N+1: quotient/remainder select, partial products
    logic [2*H-1:0] r_p00, r_p01, r_p10, r_p11;
    t_ctl           n_c2, r_c2;
    always_comb begin
        n_c2 = dt;
        if (dt.cmd == cia_pkg::C_SDIV || dt.cmd == cia_pkg::C_UDIV) n_c2.a = quo;
        if (dt.cmd == cia_pkg::C_SREM || dt.cmd == cia_pkg::C_UREM) n_c2.a = rem;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2 <= n_c2;
            r_p00 <= dt.a[H-1:0] * dt.b[H-1:0];
            r_p01 <= dt.a[H-1:0] * dt.b[W-1:H];
            r_p10 <= dt.a[W-1:H] * dt.b[H-1:0];
            r_p11 <= dt.a[W-1:H] * dt.b[W-1:H];
        end
    end

    // ---------------- stage N+2: sum products
    t_ctl n_c3, r_c3;
    always_comb begin
        n_c3 = r_c2;
        n_c3.p = {r_p11, r_p00} + ({{H{1'b0}}, r_p01, {H{1'b0}}}
                 + {{H{1'b0}}, r_p10, {H{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_c3 <= n_c3;
    end

    // ---------------- stage N+3: sign fix, final select
    t_ctl           c;
    logic [2*W-1:0] sp;
    logic [W-1:0]   lo, q;
    cia_pkg::t_out  n_out, r_out;
    always_comb begin
        c = r_c3;
        sp = (c.neg && c.p != '0) ? -c.p : c.p;
        lo = sp[W-1:0];
        q = c.neg ? -c.a : c.a;
        n_out.result = $signed(c.r);
        n_out.trap_code = c.trap;
        case (c.cmd)
            cia_pkg::C_MUL: n_out.result = $signed(f_x64(c.p[W-1:0]));
            cia_pkg::C_MULOVF: begin
                if (sp[2*W-1:W] == {W{lo[W-1]}} && f_sx(lo, c.w) == lo)
                    n_out.result = $signed(f_x64(lo));
                else n_out.trap_code = cia_pkg::T_OVF;
            end
            cia_pkg::C_SDIV, cia_pkg::C_SREM: begin
                if (c.trap == cia_pkg::T_NONE) begin
                    if (c.b == '1 && c.a == '0 && c.cmd == cia_pkg::C_SREM)
                        n_out.result = '0;
                    else n_out.result = $signed(f_x64(f_sx(q, c.w)));
                end
            end
            cia_pkg::C_UDIV, cia_pkg::C_UREM: n_out.result = $signed(f_x64(c.a));
            default: ;
        endcase
        if (n_out.trap_code != cia_pkg::T_NONE) n_out.result = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_out <= n_out;
    end

    assign o_valid = r_v[NS-1];
    assign o_data  = r_out;
endmodule

FILE: src/cia_div.sv
// ----------------------------------------------------------------------------
// cia_div
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// ----------------------------------------------------------------------------
module cia_div #(
    parameter int N = 64,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [N-1:0]  i_num,
    input  logic [N-1:0]  i_den,
    input  logic [TW-1:0] i_tag,
    output logic [N-1:0]  o_quo,
    output logic [N-1:0]  o_rem,
    output logic [TW-1:0] o_tag
);
    for (genvar k = 0; k < N; k++) begin : g_st
        logic [N-1:0]  s_q;
        logic [N-1:0]  s_r;
        logic [N-1:0]  s_d;
        logic [TW-1:0] s_t;
        logic [N:0]    n_tr;
        logic [N:0]    n_df;
        logic [N-1:0]  r_q;
        logic [N-1:0]  r_r;
        logic [N-1:0]  r_d;
        logic [TW-1:0] r_t;

        if (k == 0) begin : g_in
            assign s_q = i_num;
            assign s_r = '0;
            assign s_d = i_den;
            assign s_t = i_tag;
        end else begin : g_mid
            assign s_q = g_st[k-1].r_q;
            assign s_r = g_st[k-1].r_r;
            assign s_d = g_st[k-1].r_d;
            assign s_t = g_st[k-1].r_t;
        end

        assign n_tr = {s_r, s_q[N-1]};
        assign n_df = n_tr - {1'b0, s_d};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d <= s_d;
                r_t <= s_t;
                if (!n_df[N]) begin
                    r_r <= n_df[N-1:0];
                    r_q <= {s_q[N-2:0], 1'b1};
                end else begin
                    r_r <= n_tr[N-1:0];
                    r_q <= {s_q[N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = g_st[N-1].r_q;
    assign o_rem = g_st[N-1].r_r;
    assign o_tag = g_st[N-1].r_t;
endmodule

FILE: src/cia_chk.sv
// ----------------------------------------------------------------------------
// cia_chk
// Port-level checks for the checked integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module cia_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input cia_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out hold");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.trap_code != cia_pkg::T_NONE |-> o_data.result == '0)
        else $error("trap result");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.trap_code <= cia_pkg::T_BND) else $error("trap code");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("reset");
endmodule

bind checked_integer_alu cia_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
